// ===== rtl/min_cost_path_row_dp_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the minimum-cost falling path block
// Shared property templates used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MIN_COST_PATH_ROW_DP_DEFINES_SVH
`define MIN_COST_PATH_ROW_DP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/mcp_pkg.sv =====
// ---------------------------------------------------------------------------
// mcp_pkg
// Types, constants and helper functions of the minimum-cost path block.
// ---------------------------------------------------------------------------
package mcp_pkg;

  // Fixed field widths.
  localparam int unsigned DIST_BITS  = 32;
  localparam int unsigned START_BITS = 10;
  localparam int unsigned CFG_BITS   = 11;
  // Widest scaled cost: a 32-bit cost times seven.
  localparam int unsigned ADD_BITS   = 35;
  localparam int unsigned COLS_RESET = 1024;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Move chosen for a cell.
  typedef enum logic [1:0] {
    MOVE_TOP        = 2'd0,
    MOVE_STRAIGHT   = 2'd1,
    MOVE_FROM_RIGHT = 2'd2,
    MOVE_FROM_LEFT  = 2'd3
  } move_e;

  // One row buffer entry: path distance and its top-row start column.
  typedef struct packed {
    logic [DIST_BITS-1:0]  distance;
    logic [START_BITS-1:0] start_col;
  } entry_t;

  // Saturating add of a scaled cost to a path distance.
  function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] base,
                                                   input logic [ADD_BITS-1:0]  add);
    logic [ADD_BITS:0] sum;
    sum = (ADD_BITS+1)'(base) + (ADD_BITS+1)'(add);
    if (sum > (ADD_BITS+1)'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return sum[DIST_BITS-1:0];
  endfunction

endpackage

// ===== rtl/mcp_ram.sv =====
// ---------------------------------------------------------------------------
// mcp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read in the same cycle as a write returns the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mcp_cell_eval.sv =====
// ---------------------------------------------------------------------------
// mcp_cell_eval
// Candidate selection for one cell: straight, from the right, from the left.
// ---------------------------------------------------------------------------
module mcp_cell_eval #(
  parameter int unsigned COST_BITS = 16
) (
  input  logic                            first_row_i,
  input  logic                            has_right_i,
  input  logic                            has_left_i,
  input  logic [COST_BITS+2:0]            cost5_i,
  input  logic [COST_BITS+2:0]            cost7_i,
  input  logic [mcp_pkg::START_BITS-1:0]  self_start_i,
  input  mcp_pkg::entry_t                 up_i,
  input  mcp_pkg::entry_t                 right_i,
  input  mcp_pkg::entry_t                 left_i,
  output mcp_pkg::entry_t                 result_o,
  output mcp_pkg::move_e                  move_o
);

  logic [mcp_pkg::ADD_BITS-1:0]  add5;
  logic [mcp_pkg::ADD_BITS-1:0]  add7;
  logic [mcp_pkg::DIST_BITS-1:0] cand_up;
  logic [mcp_pkg::DIST_BITS-1:0] cand_right;
  logic [mcp_pkg::DIST_BITS-1:0] cand_left;

  assign add5 = mcp_pkg::ADD_BITS'(cost5_i);
  assign add7 = mcp_pkg::ADD_BITS'(cost7_i);

  // The three candidate sums are independent and evaluated side by side.
  assign cand_up    = mcp_pkg::sat_add(first_row_i ? '0 : up_i.distance, add5);
  assign cand_right = mcp_pkg::sat_add(right_i.distance, add7);
  assign cand_left  = mcp_pkg::sat_add(left_i.distance, add7);

  // A later candidate wins only when it is strictly cheaper.
  always_comb begin
    result_o.distance  = cand_up;
    result_o.start_col = up_i.start_col;
    move_o             = mcp_pkg::MOVE_STRAIGHT;
    if (first_row_i) begin
      result_o.start_col = self_start_i;
      move_o             = mcp_pkg::MOVE_TOP;
    end else begin
      if (has_right_i && (cand_right < result_o.distance)) begin
        result_o.distance  = cand_right;
        result_o.start_col = right_i.start_col;
        move_o             = mcp_pkg::MOVE_FROM_RIGHT;
      end
      if (has_left_i && (cand_left < result_o.distance)) begin
        result_o.distance  = cand_left;
        result_o.start_col = left_i.start_col;
        move_o             = mcp_pkg::MOVE_FROM_LEFT;
      end
    end
  end

endmodule

// ===== rtl/min_cost_path_row_dp.sv =====
// ---------------------------------------------------------------------------
// min_cost_path_row_dp
// Minimum-cost falling path over a cost matrix streamed one cell at a time.
// ---------------------------------------------------------------------------
// Cells enter in row-major order; each yields one result word through the
// cell stage and result registers, one cell per cycle while out_stall_i is
// low. The previous row lives in two copies of a MAX_COLS-deep row buffer
// with registered read, read at columns j and j+1 when a cell is accepted,
// and the result of the cell ahead is forwarded when not yet in the buffer.
// Distances are in fifths of a cost unit (straight move 5x cost, diagonal
// 7x cost) and saturate at all ones. The user must set the column width
// via the configuration channel only while idle; the block does not enforce
// this. Zero acts as one, above MAX_COLS as MAX_COLS. Row buffer contents are
// undefined until a first row has been processed at the width in use.
// ---------------------------------------------------------------------------
module min_cost_path_row_dp #(
  parameter int unsigned MAX_COLS  = 1024,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcp_pkg::CFG_BITS-1:0]   cfg_cols_in_use_i,
  // Input cell channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COST_BITS-1:0]           cost_i,
  input  logic                           start_of_matrix_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mcp_pkg::DIST_BITS-1:0]  distance_o,
  output logic [mcp_pkg::START_BITS-1:0] start_column_o,
  output logic [1:0]                     move_o,
  output logic [mcp_pkg::START_BITS-1:0] column_o,
  output logic                           row_end_o
);

  localparam int unsigned IW  = $clog2(MAX_COLS);
  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned SCW = COST_BITS + 3;
  localparam int unsigned EW  = $bits(mcp_pkg::entry_t);
  localparam int unsigned RESET_COLS =
    (mcp_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : mcp_pkg::COLS_RESET;

  // Configuration and sequencing state.
  logic [CW-1:0]   width_q;
  logic [CW-1:0]   width_d;
  logic [IW-1:0]   col_q;
  logic            first_row_q;
  mcp_pkg::entry_t saved_left_q;

  // Cell stage registers.
  logic            s1_valid_q;
  logic [SCW-1:0]  s1_cost5_q;
  logic [SCW-1:0]  s1_cost7_q;
  logic [IW-1:0]   s1_col_q;
  logic            s1_first_q;
  logic            s1_row_end_q;
  logic            s1_fwd_up_q;
  logic            s1_fwd_right_q;

  // Result registers.
  logic            out_valid_q;
  mcp_pkg::entry_t out_entry_q;
  mcp_pkg::move_e  out_move_q;
  logic [IW-1:0]   out_col_q;
  logic            out_row_end_q;

  // Combinational signals.
  logic            in_accept;
  logic            s1_adv;
  logic            col_restart;
  logic [IW-1:0]   col_now;
  logic [CW-1:0]   col_next_sum;
  logic [IW-1:0]   col_right;
  logic            row_end_now;
  logic            first_now;
  logic [SCW-1:0]  cost_ext;
  logic [EW-1:0]   ram_up_rdata;
  logic [EW-1:0]   ram_right_rdata;
  mcp_pkg::entry_t up_entry;
  mcp_pkg::entry_t right_entry;
  mcp_pkg::entry_t eval_entry;
  mcp_pkg::move_e  eval_move;

  // Handshakes: the cell stage moves on whenever the result register frees.
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Clamp the written column count into one to MAX_COLS.
  always_comb begin
    if (cfg_cols_in_use_i == '0) begin
      width_d = CW'(1);
    end else if (32'(cfg_cols_in_use_i) > 32'(MAX_COLS)) begin
      width_d = CW'(MAX_COLS);
    end else begin
      width_d = CW'(cfg_cols_in_use_i);
    end
  end

  // Column of the incoming cell and its row position.
  assign col_restart  = start_of_matrix_i || (CW'(col_q) >= width_q);
  assign col_now      = col_restart ? '0 : col_q;
  assign col_next_sum = CW'(col_now) + CW'(1);
  assign col_right    = IW'(col_next_sum);
  assign row_end_now  = (col_next_sum == width_q);
  assign first_now    = start_of_matrix_i || first_row_q;
  assign cost_ext     = SCW'(cost_i);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= CW'(RESET_COLS);
      col_q        <= '0;
      first_row_q  <= 1'b1;
      saved_left_q <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= width_d;
      end
      if (in_accept) begin
        col_q       <= row_end_now ? '0 : col_right;
        first_row_q <= row_end_now ? 1'b0 : first_now;
      end
      if (s1_adv) begin
        saved_left_q <= up_entry;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Cell stage payload; forward flags mark a read that misses the write
  // made by the cell leaving the stage at the same edge.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cost5_q     <= (cost_ext << 2) + cost_ext;
      s1_cost7_q     <= (cost_ext << 3) - cost_ext;
      s1_col_q       <= col_now;
      s1_first_q     <= first_now;
      s1_row_end_q   <= row_end_now;
      s1_fwd_up_q    <= s1_adv && (s1_col_q == col_now);
      s1_fwd_right_q <= s1_adv && (s1_col_q == col_right);
    end
  end

  // Previous-row buffer, one copy per read column.
  mcp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_COLS)
  ) u_ram_up (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (eval_entry),
    .re_i    (in_accept),
    .raddr_i (col_now),
    .rdata_o (ram_up_rdata)
  );

  mcp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_COLS)
  ) u_ram_right (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (eval_entry),
    .re_i    (in_accept),
    .raddr_i (col_right),
    .rdata_o (ram_right_rdata)
  );

  assign up_entry    = s1_fwd_up_q ? out_entry_q : mcp_pkg::entry_t'(ram_up_rdata);
  assign right_entry = s1_fwd_right_q ? out_entry_q : mcp_pkg::entry_t'(ram_right_rdata);

  // Candidate selection for the cell in the stage.
  mcp_cell_eval #(
    .COST_BITS (COST_BITS)
  ) u_cell_eval (
    .first_row_i  (s1_first_q),
    .has_right_i  (!s1_row_end_q),
    .has_left_i   (s1_col_q != '0),
    .cost5_i      (s1_cost5_q),
    .cost7_i      (s1_cost7_q),
    .self_start_i (mcp_pkg::START_BITS'(s1_col_q)),
    .up_i         (up_entry),
    .right_i      (right_entry),
    .left_i       (saved_left_q),
    .result_o     (eval_entry),
    .move_o       (eval_move)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_entry_q   <= eval_entry;
      out_move_q    <= eval_move;
      out_col_q     <= s1_col_q;
      out_row_end_q <= s1_row_end_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign distance_o     = out_entry_q.distance;
  assign start_column_o = out_entry_q.start_col;
  assign move_o         = out_move_q;
  assign column_o       = mcp_pkg::START_BITS'(out_col_q);
  assign row_end_o      = out_row_end_q;

endmodule

// ===== rtl/mcp_checker.sv =====
// ---------------------------------------------------------------------------
// mcp_checker
// Port-level checks of the minimum-cost path block, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_cost_path_row_dp_defines.svh"

module mcp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [mcp_pkg::START_BITS-1:0] start_column_o,
  input logic [1:0]                     move_o,
  input logic [mcp_pkg::START_BITS-1:0] column_o,
  input logic                           row_end_o
);

  // A stalled result word stays offered.
  `MCP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // The input side only stalls behind a result word that is itself stalled.
  `MCP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A move from the right never ends a row, since no right neighbor exists.
  `MCP_ASSERT_IMP(a_right_edge, clk_i, rst_ni, out_valid_o && move_o == mcp_pkg::MOVE_FROM_RIGHT, !row_end_o)

  // A top-row path starts in the cell's own column.
  `MCP_ASSERT_IMP(a_top_start, clk_i, rst_ni, out_valid_o && move_o == mcp_pkg::MOVE_TOP, start_column_o == column_o)

endmodule

bind min_cost_path_row_dp mcp_checker u_mcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .start_column_o (start_column_o),
  .move_o         (move_o),
  .column_o       (column_o),
  .row_end_o      (row_end_o)
);
